[design/dtbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dtbl_pkg;

  // Default grid geometry, 1 mm pitch in both directions.
  localparam int AXIAL_SIZE_DEF   = 201;
  localparam int RADIAL_SIZE_DEF  = 140;
  localparam int CENTER_INDEX_DEF = 100;

  // Fixed point format of the distances.
  localparam int FRAC_BITS = 8;
  localparam int ONE_FIX   = 1 << FRAC_BITS;

  // Field widths of the items.
  localparam int DIST_W      = 24;
  localparam int VALUE_W     = 32;
  localparam int ENTRY_IDX_W = 8;

  // Four banks, selected by row parity and column parity.
  localparam int NBANK = 4;

  // Action codes.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Configuration port.
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_TABLE_READY = '0;

endpackage

`default_nettype wire

[design/dtbl_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input channel: table writes and dose queries.
interface dtbl_in_if
  import dtbl_pkg::*;
();

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [ENTRY_IDX_W-1:0]    entry_axial;
  logic [ENTRY_IDX_W-1:0]    entry_radial;
  logic [VALUE_W-1:0]        entry_value;
  logic signed [DIST_W-1:0]  axial_mm;
  logic signed [DIST_W-1:0]  radial_mm;

  modport source (
    output valid, action, entry_axial, entry_radial, entry_value, axial_mm, radial_mm,
    input  ready
  );

  modport sink (
    input  valid, action, entry_axial, entry_radial, entry_value, axial_mm, radial_mm,
    output ready
  );

endinterface

`default_nettype wire

[design/dtbl_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Output channel: interpolated dose results.
interface dtbl_out_if
  import dtbl_pkg::*;
();

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] dose;
  logic               in_range;

  modport source (
    output valid, dose, in_range,
    input  ready
  );

  modport sink (
    input  valid, dose, in_range,
    output ready
  );

endinterface

`default_nettype wire

[design/dtbl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual port RAM with a registered read port.
module dtbl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/dose_table_bilinear_lookup_core.sv]
// Dose table with bilinear lookup.
//
// Items enter on in_i (valid/ready). An item with action write stores one
// sample at (entry_axial, entry_radial) and gives no result; writes outside
// the grid are dropped. An item with action query gives one result on out_o:
// the bilinearly interpolated dose at (axial_mm, radial_mm), or zero with
// in_range low when the table is not marked ready or the point is off-grid.
// The table_ready register sits at byte address 0 of the APB port.
//
// The datapath is a five stage pipeline: decode, bank read, corner
// multiply, partial sums, final sum. A query result is registered after
// each stage, and one item is accepted every cycle while in_i.ready is high.
// The table is split into four parity banks, so the four corners of a cell
// are read in the same cycle. A write takes effect for every later item.
// When the receiver stalls, each stage holds until the next one frees up;
// empty stages still fill, so ready stays high until the pipeline is full.
// Reset clears table_ready and all pipeline valid bits; table contents are
// undefined until written, and there is no clearing pass.

`timescale 1ns / 1ps
`default_nettype none

module dose_table_bilinear_lookup_core
  import dtbl_pkg::*;
#(
  parameter int AXIAL_SIZE   = AXIAL_SIZE_DEF,
  parameter int RADIAL_SIZE  = RADIAL_SIZE_DEF,
  parameter int CENTER_INDEX = CENTER_INDEX_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  dtbl_in_if.sink                 in_i,
  dtbl_out_if.source              out_o,
  input  wire logic               psel_i,
  input  wire logic               penable_i,
  input  wire logic               pwrite_i,
  input  wire logic [PADDR_W-1:0] paddr_i,
  input  wire logic [PDATA_W-1:0] pwdata_i,
  output logic      [PDATA_W-1:0] prdata_o,
  output logic                    pready_o
);

  // Index and datapath widths.
  localparam int ZW        = $clog2(AXIAL_SIZE + 1);
  localparam int RW        = $clog2(RADIAL_SIZE + 1);
  localparam int ZRW       = (ZW > RW) ? ZW : RW;
  localparam int EW        = (ZRW > ENTRY_IDX_W) ? ZRW : ENTRY_IDX_W;
  localparam int PW        = DIST_W + 2;
  localparam int MW        = DIST_W + 1;
  localparam int FW        = FRAC_BITS + 1;
  localparam int WW        = 2 * FRAC_BITS + 1;
  localparam int PROD_W    = VALUE_W + 2 * FRAC_BITS;
  localparam int HALF_A    = (AXIAL_SIZE + 1) / 2;
  localparam int HALF_R    = (RADIAL_SIZE + 1) / 2;
  localparam int BANK_DEPTH = HALF_A * HALF_R;
  localparam int BANK_AW   = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  localparam logic signed [PW-1:0] CENTER_FIX = PW'(CENTER_INDEX * ONE_FIX);
  localparam logic [PW-1:0]        AXIAL_LIM  = PW'(AXIAL_SIZE * ONE_FIX);
  localparam logic [MW-1:0]        RADIAL_LIM = MW'(RADIAL_SIZE * ONE_FIX);
  localparam logic [FW-1:0]        ONE_W      = FW'(ONE_FIX);

  // Word address of a grid point inside its parity bank.
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [ZW-1:0] row,
                                                   input logic [RW-1:0] col);
    bank_addr = BANK_AW'(int'(row[ZW-1:1]) * HALF_R + int'(col[RW-1:1]));
  endfunction

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic table_ready_q, table_ready_d;

  always_comb begin
    table_ready_d = table_ready_q;
    if (psel_i && penable_i && pwrite_i) begin
      unique case (paddr_i[PADDR_W-1:2])
        REG_TABLE_READY: table_ready_d = pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr_i[PADDR_W-1:2])
      REG_TABLE_READY: prdata_o = PDATA_W'(table_ready_q);
      default:         prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_ready_q <= 1'b0;
    end else begin
      table_ready_q <= table_ready_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage enables: a stage loads when it is empty or the next one loads.
  // ---------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, en_o;

  assign en_o = !vo_q || out_o.ready;
  assign en4  = !v4_q || en_o;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;

  assign in_i.ready = en1;

  // ---------------------------------------------------------------------
  // Stage 0: position decode and range check on the incoming item.
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] apos;
  logic signed [MW-1:0] rsgn;
  logic [MW-1:0]        rmag;
  logic                 axial_out, radial_out, query_ok;
  logic [EW-1:0]        wrow_ext, wcol_ext;
  logic                 write_ok;
  logic                 is_query;

  assign is_query   = (in_i.action == ACT_QUERY);
  assign apos       = CENTER_FIX + PW'(in_i.axial_mm);
  assign rsgn       = MW'(in_i.radial_mm);
  assign rmag       = rsgn[MW-1] ? unsigned'(-rsgn) : unsigned'(rsgn);
  assign axial_out  = apos[PW-1] || (unsigned'(apos) >= AXIAL_LIM);
  assign radial_out = (rmag >= RADIAL_LIM);
  assign query_ok   = table_ready_q && !axial_out && !radial_out;

  assign wrow_ext = EW'(in_i.entry_axial);
  assign wcol_ext = EW'(in_i.entry_radial);
  assign write_ok = (wrow_ext < EW'(AXIAL_SIZE)) && (wcol_ext < EW'(RADIAL_SIZE));

  // Stage 1 registers.
  logic                 q1_q, ok1_q;
  logic [ZW-1:0]        z0_1_q;
  logic [RW-1:0]        r0_1_q;
  logic [FRAC_BITS-1:0] fz_1_q, fr_1_q;
  logic [VALUE_W-1:0]   wdata_1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      q1_q      <= is_query;
      ok1_q     <= is_query ? query_ok : write_ok;
      z0_1_q    <= is_query ? apos[ZW+FRAC_BITS-1:FRAC_BITS] : wrow_ext[ZW-1:0];
      r0_1_q    <= is_query ? rmag[RW+FRAC_BITS-1:FRAC_BITS] : wcol_ext[RW-1:0];
      fz_1_q    <= apos[FRAC_BITS-1:0];
      fr_1_q    <= rmag[FRAC_BITS-1:0];
      wdata_1_q <= in_i.entry_value;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: neighbor indices, bank addresses, weights; bank access.
  // ---------------------------------------------------------------------
  logic          zc_1, rc_1;
  logic [ZW-1:0] z1_1;
  logic [RW-1:0] r1_1;
  logic [FW-1:0] fz_w, fr_w, fz_c, fr_c;
  logic [WW-1:0] w_1 [NBANK];
  logic [VALUE_W-1:0] rdata [NBANK];

  assign zc_1 = (z0_1_q == ZW'(AXIAL_SIZE - 1));
  assign rc_1 = (r0_1_q == RW'(RADIAL_SIZE - 1));
  assign z1_1 = zc_1 ? z0_1_q : z0_1_q + ZW'(1);
  assign r1_1 = rc_1 ? r0_1_q : r0_1_q + RW'(1);

  assign fz_w = FW'(fz_1_q);
  assign fr_w = FW'(fr_1_q);
  assign fz_c = ONE_W - fz_w;
  assign fr_c = ONE_W - fr_w;

  // Corner order: (z0,r0), (z0,r1), (z1,r0), (z1,r1).
  assign w_1[0] = WW'(fr_c * fz_c);
  assign w_1[1] = WW'(fr_w * fz_c);
  assign w_1[2] = WW'(fr_c * fz_w);
  assign w_1[3] = WW'(fr_w * fz_w);

  // Bank b holds rows of parity b[1] and columns of parity b[0].
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    localparam logic ROW_PAR = 1'(b >> 1);
    localparam logic COL_PAR = 1'(b & 1);

    logic [ZW-1:0]      rd_row;
    logic [RW-1:0]      rd_col;
    logic [BANK_AW-1:0] raddr;
    logic               we;

    assign rd_row = (z0_1_q[0] == ROW_PAR) ? z0_1_q : z1_1;
    assign rd_col = (r0_1_q[0] == COL_PAR) ? r0_1_q : r1_1;
    assign raddr  = bank_addr(rd_row, rd_col);
    assign we     = en2 && v1_q && !q1_q && ok1_q &&
                    (z0_1_q[0] == ROW_PAR) && (r0_1_q[0] == COL_PAR);

    dtbl_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (bank_addr(z0_1_q, r0_1_q)),
      .wdata_i (wdata_1_q),
      .re_i    (en2),
      .raddr_i (raddr),
      .rdata_o (rdata[b])
    );
  end

  // Stage 2 registers; the bank data registers sit inside the RAMs.
  logic          ok2_q, zp2_q, zc2_q, rp2_q, rc2_q;
  logic [WW-1:0] w2_q [NBANK];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      ok2_q <= ok1_q;
      zp2_q <= z0_1_q[0];
      zc2_q <= zc_1;
      rp2_q <= r0_1_q[0];
      rc2_q <= rc_1;
      w2_q  <= w_1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: route bank data to corners and weight each corner.
  // ---------------------------------------------------------------------
  logic               zp_hi, rp_hi;
  logic [VALUE_W-1:0] corner [NBANK];
  logic [PROD_W-1:0]  prod   [NBANK];

  // A clamped upper neighbor reads the same bank as the lower one.
  assign zp_hi = zc2_q ? zp2_q : !zp2_q;
  assign rp_hi = rc2_q ? rp2_q : !rp2_q;

  assign corner[0] = rdata[{zp2_q, rp2_q}];
  assign corner[1] = rdata[{zp2_q, rp_hi}];
  assign corner[2] = rdata[{zp_hi, rp2_q}];
  assign corner[3] = rdata[{zp_hi, rp_hi}];

  for (genvar k = 0; k < NBANK; k++) begin : g_mul
    assign prod[k] = PROD_W'(corner[k]) * PROD_W'(w2_q[k]);
  end

  // Stage 3 registers.
  logic              ok3_q;
  logic [PROD_W-1:0] prod3_q [NBANK];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      ok3_q   <= ok2_q;
      prod3_q <= prod;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: pairwise sums. The weights add up to one, so no carry out.
  // ---------------------------------------------------------------------
  logic              ok4_q;
  logic [PROD_W-1:0] sum_a4_q, sum_b4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      ok4_q    <= ok3_q;
      sum_a4_q <= prod3_q[0] + prod3_q[1];
      sum_b4_q <= prod3_q[2] + prod3_q[3];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: final sum, drop the fraction bits, zero when off-grid or not ready.
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0]  sum_total;
  logic [VALUE_W-1:0] dose_q;
  logic               in_range_q;

  assign sum_total = sum_a4_q + sum_b4_q;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      dose_q     <= ok4_q ? sum_total[PROD_W-1:2*FRAC_BITS] : '0;
      in_range_q <= ok4_q;
    end
  end

  // Valid bits; write items leave the pipeline after the bank access.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q && q1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (en_o) begin
        vo_q <= v4_q;
      end
    end
  end

  assign out_o.valid    = vo_q;
  assign out_o.dose     = dose_q;
  assign out_o.in_range = in_range_q;

endmodule

`default_nettype wire
